### rtl/cmbgo_pkg.sv
// Shared types and constants for the gray-ordered color morphology block.
// Used by every module under rtl/ but cmbgo_store; depends on nothing.
package cmbgo_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 256;
  localparam int unsigned MAX_HEIGHT_DEF  = 256;
  localparam int unsigned WINDOW_SIZE_DEF = 3;

  // Number of shape-mask bits held by the register.
  localparam int unsigned MASK_BITS = 9;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MASK   = 2'd3;

  // Item action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Operation codes.
  localparam logic OP_DILATE = 1'b0;
  localparam logic OP_ERODE  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] gray_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] gray_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] src_col;
    logic [7:0] src_row;
  } out_beat_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic       load;   // take the candidate as the starting best
    logic       cmp;    // compare the candidate against the best
    logic       erode;  // keep the least gray instead of the greatest
    logic [7:0] col;
    logic [7:0] row;
  } sel_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

### rtl/cmbgo_store.sv
// Frame store: one word of gray, red, green, blue per pixel.
// Single address, registered read data. Depends on nothing.
module cmbgo_store #(
  parameter int unsigned Depth = 65536
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [31:0]                              wdata_i,
  output logic [31:0]                              rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cmbgo_sel.sv
// Shared compare unit: keeps the best pixel seen so far in a window scan.
// Depends on cmbgo_pkg.
module cmbgo_sel (
  input  logic                 clk_i,
  input  cmbgo_pkg::sel_ctrl_t ctrl_i,
  input  logic [31:0]          word_i,
  output logic [31:0]          best_word_o,
  output logic [7:0]           best_col_o,
  output logic [7:0]           best_row_o
);

  import cmbgo_pkg::*;

  logic [31:0] best_word_q, best_word_d;
  logic [7:0]  best_col_q, best_col_d;
  logic [7:0]  best_row_q, best_row_d;
  logic [7:0]  cand_gray, best_gray;
  logic        better;

  assign cand_gray = word_i[31:24];
  assign best_gray = best_word_q[31:24];

  // strict compare, so ties keep the earlier pixel
  always_comb begin
    case (ctrl_i.erode)
      OP_ERODE: better = cand_gray < best_gray;
      default:  better = cand_gray > best_gray;
    endcase
  end

  always_comb begin
    best_word_d = best_word_q;
    best_col_d  = best_col_q;
    best_row_d  = best_row_q;
    if (ctrl_i.load || (ctrl_i.cmp && better)) begin
      best_word_d = word_i;
      best_col_d  = ctrl_i.col;
      best_row_d  = ctrl_i.row;
    end
  end

  always_ff @(posedge clk_i) begin
    best_word_q <= best_word_d;
    best_col_q  <= best_col_d;
    best_row_q  <= best_row_d;
  end

  assign best_word_o = best_word_q;
  assign best_col_o  = best_col_q;
  assign best_row_o  = best_row_q;

endmodule

### rtl/cmbgo_ctrl.sv
// Sequencer: configuration registers, window walk, store addressing and
// control of the compare unit. Depends on cmbgo_pkg.
module cmbgo_ctrl #(
  parameter int unsigned MaxWidth   = cmbgo_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight  = cmbgo_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned WindowSize = cmbgo_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned AddrW      = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cmbgo_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmbgo_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  cmbgo_pkg::in_beat_t                  in_data_i,
  input  logic                                 out_free_i,
  output logic                                 mem_we_o,
  output logic                                 mem_re_o,
  output logic [AddrW-1:0]                     mem_addr_o,
  output logic [31:0]                          mem_wdata_o,
  output cmbgo_pkg::sel_ctrl_t                 sel_ctrl_o,
  output logic                                 done_o,
  output logic                                 inval_o
);

  import cmbgo_pkg::*;

  localparam int unsigned Radius = WindowSize / 2;
  localparam int unsigned CntW   = WindowSize > 1 ? $clog2(WindowSize) : 1;
  localparam int unsigned PosN   = WindowSize * WindowSize;
  localparam int unsigned PosW   = PosN > 1 ? $clog2(PosN) : 1;
  localparam int unsigned IdxW   = PosW > 4 ? PosW : 4;
  localparam logic [CntW-1:0] CntLast = CntW'(WindowSize - 1);

  state_e state_q, state_d;

  logic [8:0]          fw_q, fh_q;
  logic                op_q;
  logic [MASK_BITS-1:0] mask_q;

  logic [7:0]      col_q, col_d, row_q, row_d;
  logic [CntW-1:0] xi_q, xi_d, yj_q, yj_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            inval_q, inval_d;
  logic            pend_q, pend_d, init_q, init_d;
  logic [7:0]      pcol_q, pcol_d, prow_q, prow_d;

  logic [8:0]        fw_eff, fh_eff;
  logic              accept, q_outside, last_pos, pos_ok, mask_bit;
  logic signed [9:0] px_s, py_s;
  logic [8:0]        ax, ay;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 9'd256;
      fh_q   <= 9'd256;
      op_q   <= OP_DILATE;
      mask_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i;
        CFG_OPERATION:    op_q   <= cfg_data_i[0];
        CFG_SHAPE_MASK:   mask_q <= cfg_data_i[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Saturate frame size to the store geometry
  assign fw_eff = (32'(fw_q) > MaxWidth)  ? 9'(MaxWidth)  : fw_q;
  assign fh_eff = (32'(fh_q) > MaxHeight) ? 9'(MaxHeight) : fh_q;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign q_outside = ({1'b0, in_data_i.col} >= fw_eff) || ({1'b0, in_data_i.row} >= fh_eff);
  assign last_pos  = (xi_q == CntLast) && (yj_q == CntLast);

  // Window position relative to the centre
  assign px_s = $signed({2'b00, col_q}) + $signed(10'(xi_q)) - $signed(10'(Radius));
  assign py_s = $signed({2'b00, row_q}) + $signed(10'(yj_q)) - $signed(10'(Radius));

  assign mask_bit = (32'(pos_q) < MASK_BITS) ? mask_q[pos_q[3:0]] : 1'b0;
  assign pos_ok   = (px_s >= 10'sd0) && (px_s < $signed({1'b0, fw_eff}))
                 && (py_s >= 10'sd0) && (py_s < $signed({1'b0, fh_eff}))
                 && mask_bit;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_data_i.action == ACT_QUERY) begin
          state_d = q_outside ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_pos) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath registers
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    xi_d     = xi_q;
    yj_d     = yj_q;
    pos_d    = pos_q;
    inval_d  = inval_q;
    pend_d   = 1'b0;
    init_d   = 1'b0;
    ax       = {1'b0, in_data_i.col};
    ay       = {1'b0, in_data_i.row};
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    done_o   = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (in_data_i.action == ACT_WRITE) begin
            mem_we_o = (32'(in_data_i.col) < MaxWidth) && (32'(in_data_i.row) < MaxHeight);
          end else begin
            // issue the centre read right away; it seeds the best pixel
            col_d    = in_data_i.col;
            row_d    = in_data_i.row;
            xi_d     = '0;
            yj_d     = '0;
            pos_d    = '0;
            inval_d  = q_outside;
            mem_re_o = !q_outside;
            pend_d   = !q_outside;
            init_d   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ax       = px_s[8:0];
        ay       = py_s[8:0];
        mem_re_o = pos_ok;
        pend_d   = pos_ok;
        pos_d    = pos_q + 1'b1;
        if (yj_q == CntLast) begin
          yj_d = '0;
          xi_d = xi_q + 1'b1;
        end else begin
          yj_d = yj_q + 1'b1;
        end
      end
      ST_DRAIN: ;
      ST_DONE: done_o = out_free_i;
      default: ;
    endcase
  end

  assign pcol_d = ax[7:0];
  assign prow_d = ay[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      init_q  <= 1'b0;
      inval_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      init_q  <= init_d;
      inval_q <= inval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    xi_q   <= xi_d;
    yj_q   <= yj_d;
    pos_q  <= pos_d;
    pcol_q <= pcol_d;
    prow_q <= prow_d;
  end

  assign mem_addr_o  = AddrW'(AddrW'(ay) * AddrW'(MaxWidth) + AddrW'(ax));
  assign mem_wdata_o = {in_data_i.gray_in, in_data_i.red_in,
                        in_data_i.green_in, in_data_i.blue_in};

  // Compare the word read in the previous cycle
  assign sel_ctrl_o.load  = pend_q && init_q;
  assign sel_ctrl_o.cmp   = pend_q && !init_q;
  assign sel_ctrl_o.erode = op_q;
  assign sel_ctrl_o.col   = pcol_q;
  assign sel_ctrl_o.row   = prow_q;

  assign inval_o = inval_q;

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_free_i && state_q == ST_DONE)
    else $error("result issued while output stage busy");

  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store read and write in one cycle");

  a_scan_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && $past(state_q) == ST_IDLE |-> pend_q && init_q)
    else $error("window scan started without centre read");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |=> state_q == ST_DONE && !pend_q)
    else $error("drain did not settle the compare unit");

endmodule

### rtl/color_morpho_by_gray_order.sv
// Top level of the gray-ordered color morphology block: sequencer, frame store,
// shared compare unit and output register. Depends on cmbgo_pkg and all rtl modules.
//
//   channel | direction | handshake                  | beat
//   in      | input     | in_valid_i / in_ready_o    | cmbgo_pkg::in_beat_t
//   out     | output    | out_valid_o / out_ready_i  | cmbgo_pkg::out_beat_t
//   cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// A write beat is written to the store in the accepting cycle. A query inside the frame
// runs these steps: the centre read in the accepting cycle, a store read through the
// single store port for each window position inside the frame and set in the shape mask,
// a drain state for the compare unit and a done state that loads the output register.
// A query outside the frame goes straight to the done state.
// The next beat is taken while a result waits; a query stalls at its end until the
// output register is free. Reset clears control and configuration, not the store.
module color_morpho_by_gray_order #(
  parameter int unsigned MAX_WIDTH   = cmbgo_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = cmbgo_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned WINDOW_SIZE = cmbgo_pkg::WINDOW_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmbgo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmbgo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cmbgo_pkg::in_beat_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cmbgo_pkg::out_beat_t             out_data_o
);

  import cmbgo_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = Depth > 1 ? $clog2(Depth) : 1;

  logic             mem_we, mem_re, done, inval, out_free;
  logic [AddrW-1:0] mem_addr;
  logic [31:0]      mem_wdata, mem_rdata, best_word;
  logic [7:0]       best_col, best_row;
  sel_ctrl_t        sel_ctrl;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  assign out_free = !out_valid_q || out_ready_i;

  cmbgo_ctrl #(
    .MaxWidth   (MAX_WIDTH),
    .MaxHeight  (MAX_HEIGHT),
    .WindowSize (WINDOW_SIZE),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .sel_ctrl_o  (sel_ctrl),
    .done_o      (done),
    .inval_o     (inval)
  );

  cmbgo_store #(
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  cmbgo_sel u_sel (
    .clk_i       (clk_i),
    .ctrl_i      (sel_ctrl),
    .word_i      (mem_rdata),
    .best_word_o (best_word),
    .best_col_o  (best_col),
    .best_row_o  (best_row)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (done) begin
      out_valid_d = 1'b1;
      if (inval) begin
        out_d = '0;
      end else begin
        out_d.valid_res = 1'b1;
        out_d.gray_out  = best_word[31:24];
        out_d.red_out   = best_word[23:16];
        out_d.green_out = best_word[15:8];
        out_d.blue_out  = best_word[7:0];
        out_d.src_col   = best_col;
        out_d.src_row   = best_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
